### hw/rtl/pkh_pkg.sv
// ----------------------------------------------------------------------------
// pkh_pkg
// Shared constants, status codes and types of the pointer-key hash map.
// ----------------------------------------------------------------------------
package pkh_pkg;

    localparam int TABLE_SLOTS  = 1024;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS     = SLOT_BITS + 1;
    localparam int KEY_BITS     = 48;
    localparam int PAYLOAD_BITS = 64;
    localparam int LIMIT_BITS   = 10;
    localparam int STATUS_BITS  = 3;
    localparam int CMP_BITS     = ((CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS) + 1;
    localparam int ENTRY_BITS   = 1 + KEY_BITS + PAYLOAD_BITS;

    localparam logic [63:0] FIB_MULT = 64'h9E3779B97F4A7C15;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(716);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic                    func;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] value;
        logic [SLOT_BITS-1:0]    home;
    } item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

### hw/rtl/pointer_key_hash_map.sv
// ----------------------------------------------------------------------------
// pointer_key_hash_map
// Open-addressing key/payload map with linear probing and a load limit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_stall  | func, key, entry_value
//   out      | out_valid / out_stall| status, found_value, slot_index
//   cfg      | cfg_valid / cfg_ready| load_limit
//
// after reset a clearing pass invalidates every slot; in_stall
// stays high meanwhile, cfg writes are taken as usual
// a transaction is dispatched from the queue, probes slots one after another
// (read port of the slot memory), then lands in the result register
// a two-entry queue keeps accepting until full while the probe engine works
// or waits on out_stall
// ----------------------------------------------------------------------------
module pointer_key_hash_map (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [pkh_pkg::KEY_BITS-1:0]        key,
    input  logic [pkh_pkg::PAYLOAD_BITS-1:0]    entry_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pkh_pkg::STATUS_BITS-1:0]     status,
    output logic [pkh_pkg::PAYLOAD_BITS-1:0]    found_value,
    output logic [pkh_pkg::SLOT_BITS-1:0]       slot_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pkh_pkg::LIMIT_BITS-1:0]      load_limit
);

    logic [pkh_pkg::LIMIT_BITS-1:0] limit_reg, limit_next;
    pkh_pkg::item_t                 head;
    logic                           head_valid;
    pkh_pkg::back_ctl_t             ctl;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? load_limit : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pkh_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    pkh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .entry_value (entry_value),
        .ctl         (ctl),
        .head        (head),
        .head_valid  (head_valid)
    );

    pkh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .limit       (limit_reg),
        .ctl         (ctl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value),
        .slot_index  (slot_index)
    );

endmodule

### hw/rtl/pkh_ram.sv
// ----------------------------------------------------------------------------
// pkh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/pkh_front.sv
// ----------------------------------------------------------------------------
// pkh_front
// Input side: accepts transactions, hashes the key to its home slot and
// holds them in a two-entry queue for the probe engine.
// ----------------------------------------------------------------------------
module pkh_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [pkh_pkg::KEY_BITS-1:0]     key,
    input  logic [pkh_pkg::PAYLOAD_BITS-1:0] entry_value,
    input  pkh_pkg::back_ctl_t               ctl,
    output pkh_pkg::item_t                   head,
    output logic                             head_valid
);

    logic [1:0]     cnt_reg, cnt_next;
    pkh_pkg::item_t q0_reg, q0_next;
    pkh_pkg::item_t q1_reg, q1_next;
    pkh_pkg::item_t new_item;
    logic           push;

    logic [pkh_pkg::KEY_BITS+pkh_pkg::SLOT_BITS-1:0] key_ext;
    logic [pkh_pkg::SLOT_BITS-1:0]                   key_sh;
    logic [2*pkh_pkg::SLOT_BITS-1:0]                 prod;

    // only the low slot bits of the product matter, so a narrow multiply does
    assign key_ext = {{pkh_pkg::SLOT_BITS{1'b0}}, key};
    assign key_sh  = key_ext[3 +: pkh_pkg::SLOT_BITS];
    assign prod    = key_sh * pkh_pkg::FIB_MULT[pkh_pkg::SLOT_BITS-1:0];

    always_comb
    begin
        new_item.func  = func;
        new_item.key   = key;
        new_item.value = entry_value;
        new_item.home  = prod[pkh_pkg::SLOT_BITS-1:0];
    end

    assign in_stall   = (cnt_reg == 2'd2) || ctl.clearing;
    assign push       = in_valid && !in_stall;
    assign head       = q0_reg;
    assign head_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (ctl.pop)
        begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        if (push)
        begin
            priority if (cnt_next == 2'd0)
            begin
                q0_next = new_item;
            end
            else
            begin
                q1_next = new_item;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

### hw/rtl/pkh_back.sv
// ----------------------------------------------------------------------------
// pkh_back
// Probe engine: clears the table after reset, walks slots linearly from the
// home slot, inserts or looks up, and holds the result in an output register.
// ----------------------------------------------------------------------------
module pkh_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pkh_pkg::item_t                      head,
    input  logic                                head_valid,
    input  logic [pkh_pkg::LIMIT_BITS-1:0]      limit,
    output pkh_pkg::back_ctl_t                  ctl,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pkh_pkg::STATUS_BITS-1:0]     status,
    output logic [pkh_pkg::PAYLOAD_BITS-1:0]    found_value,
    output logic [pkh_pkg::SLOT_BITS-1:0]       slot_index
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [pkh_pkg::SLOT_BITS-1:0]     clr_reg, clr_next;
    logic [pkh_pkg::SLOT_BITS-1:0]     idx_reg, idx_next;
    logic [pkh_pkg::SLOT_BITS-1:0]     probes_reg, probes_next;
    logic [pkh_pkg::CNT_BITS-1:0]      count_reg, count_next;
    pkh_pkg::item_t                    cur_reg, cur_next;
    logic                              res_valid_reg, res_valid_next;
    logic [pkh_pkg::STATUS_BITS-1:0]   status_reg, status_next;
    logic [pkh_pkg::PAYLOAD_BITS-1:0]  value_reg, value_next;
    logic [pkh_pkg::SLOT_BITS-1:0]     slot_reg, slot_next;

    logic                              wr_en, rd_en;
    logic [pkh_pkg::SLOT_BITS-1:0]     wr_addr, rd_addr;
    logic [pkh_pkg::ENTRY_BITS-1:0]    wr_data, rd_data;

    logic                              e_valid, e_match, done, res_free, room;
    logic [pkh_pkg::KEY_BITS-1:0]      e_key;
    logic [pkh_pkg::PAYLOAD_BITS-1:0]  e_payload;
    logic [pkh_pkg::SLOT_BITS-1:0]     idx_inc;
    logic [pkh_pkg::CMP_BITS-1:0]      need, lim_ext;

    pkh_ram #(
        .WIDTH (pkh_pkg::ENTRY_BITS),
        .DEPTH (pkh_pkg::TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign e_valid   = rd_data[pkh_pkg::ENTRY_BITS-1];
    assign e_key     = rd_data[pkh_pkg::PAYLOAD_BITS +: pkh_pkg::KEY_BITS];
    assign e_payload = rd_data[pkh_pkg::PAYLOAD_BITS-1:0];
    assign e_match   = e_valid && (e_key == cur_reg.key);
    assign done      = !e_valid || e_match || (probes_reg == '1);
    assign res_free  = !res_valid_reg || !out_stall;
    assign idx_inc   = idx_reg + pkh_pkg::SLOT_BITS'(1);

    // entry_count + 1 against the limit
    assign need    = pkh_pkg::CMP_BITS'(count_reg) + pkh_pkg::CMP_BITS'(1);
    assign lim_ext = pkh_pkg::CMP_BITS'(limit);
    assign room    = (need <= lim_ext);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        probes_next    = probes_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg && out_stall;
        status_next    = status_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        ctl.pop        = 1'b0;
        ctl.clearing   = (state_reg == S_CLEAR);
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = {1'b1, cur_reg.key, cur_reg.value};
        rd_en          = 1'b0;
        rd_addr        = idx_inc;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + pkh_pkg::SLOT_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    ctl.pop     = 1'b1;
                    cur_next    = head;
                    idx_next    = head.home;
                    probes_next = '0;
                    rd_en       = 1'b1;
                    rd_addr     = head.home;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!done)
                begin
                    idx_next    = idx_inc;
                    probes_next = probes_reg + pkh_pkg::SLOT_BITS'(1);
                    rd_en       = 1'b1;
                end
                else if (res_free)
                begin
                    // hold in this state with the read data stable until the
                    // output register can take the result
                    res_valid_next = 1'b1;
                    value_next     = '0;
                    slot_next      = '0;
                    state_next     = S_IDLE;
                    priority if (e_match)
                    begin
                        slot_next = idx_reg;
                        if (cur_reg.func == pkh_pkg::FUNC_LOOKUP)
                        begin
                            status_next = pkh_pkg::ST_FOUND;
                            value_next  = e_payload;
                        end
                        else
                        begin
                            status_next = pkh_pkg::ST_DUPLICATE;
                        end
                    end
                    else if (cur_reg.func == pkh_pkg::FUNC_LOOKUP)
                    begin
                        status_next = pkh_pkg::ST_NOT_FOUND;
                    end
                    else if (!e_valid && room)
                    begin
                        wr_en       = 1'b1;
                        count_next  = count_reg + pkh_pkg::CNT_BITS'(1);
                        status_next = pkh_pkg::ST_INSERTED;
                        slot_next   = idx_reg;
                    end
                    else
                    begin
                        status_next = pkh_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        probes_reg <= probes_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
    end

    assign out_valid   = res_valid_reg;
    assign status      = status_reg;
    assign found_value = value_reg;
    assign slot_index  = slot_reg;

endmodule

### hw/rtl/pkh_checker.sv
// ----------------------------------------------------------------------------
// pkh_checker
// Port-level checks of the hash map, bound to the top level.
// ----------------------------------------------------------------------------
module pkh_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [pkh_pkg::STATUS_BITS-1:0]     status,
    input  logic [pkh_pkg::PAYLOAD_BITS-1:0]    found_value,
    input  logic [pkh_pkg::SLOT_BITS-1:0]       slot_index
);

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(found_value) && $stable(slot_index))
        else $error("result changed while stalled");

    // payload only comes back on a hit
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pkh_pkg::ST_FOUND) |-> found_value == '0)
        else $error("nonzero value without a hit");

    // misses and refusals report slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == pkh_pkg::ST_NOT_FOUND || status == pkh_pkg::ST_FULL)
            |-> slot_index == '0)
        else $error("slot index on miss or full");

    // clearing pass holds off input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input taken during clearing pass");

    // no result can show up right out of reset
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind pointer_key_hash_map pkh_checker u_pkh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .slot_index  (slot_index)
);
